>>> design/wpcrc_pkg.sv
// Shared types and the CRC-16 word update for the word padded CRC core.
package wpcrc_pkg;

    localparam int unsigned CRC_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8005;

    // Byte count codes, saturating at three
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_MANY = 2'd3;

    // Finish request from the accumulator to the output stage
    typedef struct packed {
        logic [CRC_W-1:0] crc;     // register value, or the result itself on bypass
        logic [CRC_W-1:0] word;    // last word to shift in
        logic             bypass;  // short message: crc is the result as is
    } t_fin;

    // Shift one 16-bit word into the register, MSB first.
    // Linear in both arguments, so it flattens to a shallow XOR network.
    function automatic logic [CRC_W-1:0] crc_shift_word(
        input logic [CRC_W-1:0] reg_in,
        input logic [CRC_W-1:0] word
    );
        logic [CRC_W-1:0] r;
        logic             top;
        r = reg_in;
        for (int i = 0; i < CRC_W; i++) begin
            top = r[CRC_W-1];
            r   = {r[CRC_W-2:0], word[CRC_W-1-i]};
            if (top) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

>>> design/wpcrc_accum.sv
// Per-message state: start value load, word pairing and finish request.
module wpcrc_accum
    import wpcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output logic              o_take,
    output logic              o_fin_valid,
    output t_fin              o_fin,
    input  logic              i_fin_take
);

    logic [CRC_W-1:0]  r_crc, n_crc;
    logic [BYTE_W-1:0] r_held, n_held;
    logic [1:0]        r_cnt, n_cnt;
    logic              r_odd, n_odd;
    logic              r_fin_valid;
    t_fin              r_fin, n_fin;
    logic              w_fin_free;

    // A last byte needs a free finish slot; other bytes always go
    assign w_fin_free = !r_fin_valid || i_fin_take;
    assign o_take     = i_valid && (!i_last || w_fin_free);

    // Next state and finish request for the byte at the input register
    always_comb begin
        n_crc  = r_crc;
        n_held = r_held;
        n_odd  = r_odd;
        n_fin  = '0;
        n_cnt  = (r_cnt == CNT_MANY) ? CNT_MANY : r_cnt + 2'd1;
        case (r_cnt)
            CNT_NONE: begin
                n_held     = i_byte;
                n_fin.bypass = 1'b1;
            end
            CNT_ONE: begin
                n_crc        = {r_held, i_byte};
                n_fin.crc    = {r_held, i_byte};
                n_fin.bypass = 1'b1;
            end
            default: begin
                if (!r_odd) begin
                    // odd tail: pad with a zero low byte
                    n_held     = i_byte;
                    n_odd      = 1'b1;
                    n_fin.crc  = r_crc;
                    n_fin.word = {i_byte, {BYTE_W{1'b0}}};
                end else begin
                    // even tail: full word, then one zero word at the end
                    n_crc      = crc_shift_word(r_crc, {r_held, i_byte});
                    n_odd      = 1'b0;
                    n_fin.crc  = n_crc;
                    n_fin.word = '0;
                end
            end
        endcase
    end

    // State registers; a last byte returns the state to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= '0;
            r_held      <= '0;
            r_cnt       <= CNT_NONE;
            r_odd       <= 1'b0;
            r_fin_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (i_last) begin
                    r_crc  <= '0;
                    r_held <= '0;
                    r_cnt  <= CNT_NONE;
                    r_odd  <= 1'b0;
                end else begin
                    r_crc  <= n_crc;
                    r_held <= n_held;
                    r_cnt  <= n_cnt;
                    r_odd  <= n_odd;
                end
            end
            if (o_take && i_last) begin
                r_fin_valid <= 1'b1;
            end else if (i_fin_take) begin
                r_fin_valid <= 1'b0;
            end
        end
    end

    // Finish payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_last) begin
            r_fin <= n_fin;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

endmodule

>>> design/wpcrc_out.sv
// Final word shift and the result register on the master side.
module wpcrc_out
    import wpcrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fin_valid,
    input  t_fin             i_fin,
    output logic             o_fin_take,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [CRC_W-1:0] o_m_tdata   // [15:0] checksum
);

    logic             r_valid;
    logic [CRC_W-1:0] r_data, n_data;

    assign o_fin_take = i_fin_valid && (!r_valid || i_m_tready);

    // Short messages pass through; others take the last word
    always_comb begin
        if (i_fin.bypass) begin
            n_data = i_fin.crc;
        end else begin
            n_data = crc_shift_word(i_fin.crc, i_fin.word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_fin_take) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_take) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

>>> design/word_padded_crc16_core.sv
// Top level: byte input register, message accumulator and result stage.
// A tlast byte reaches o_m_tvalid via the input, finish and result registers.
// Throughput: one byte per cycle unless a last byte waits for the finish slot.
// A stalled result holds the finish slot; bytes keep flowing until a
// second last byte needs it.
// Reset (i_rst_n low, synchronous) clears all valid flags and message state.
module word_padded_crc16_core
    import wpcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] data_byte
    input  logic              i_s_tlast,   // last_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [CRC_W-1:0]  o_m_tdata    // [15:0] checksum
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              w_in_take;
    logic              w_fin_valid;
    logic              w_fin_take;
    t_fin              w_fin;

    // Input register
    assign o_s_tready = !r_in_valid || w_in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    wpcrc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_take      (w_in_take),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin),
        .i_fin_take  (w_fin_take)
    );

    wpcrc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (w_fin_valid),
        .i_fin       (w_fin),
        .o_fin_take  (w_fin_take),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // Reset empties the input register and the finish and result stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !w_fin_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

    // A byte that ends no message never waits in the input register
    a_mid_byte_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_last) |-> w_in_take)
        else $error("mid-message byte stalled");

    // A pending finish request is not lost while the result stage is full
    a_fin_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_valid && !w_fin_take) |=> w_fin_valid)
        else $error("finish request dropped");

    // A new result enters only through a finish request
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && !w_fin_valid) |=> !o_m_tvalid)
        else $error("result without finish request");

endmodule

>>> tb/word_padded_crc16_checker.sv
// Checker for the word padded CRC-16 core: watches both streams, predicts checksums, compares.
`timescale 1ns / 100ps

module word_padded_crc16_checker
    import wpcrc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,    // [7:0] data_byte
    input  logic              i_s_tlast,    // last_byte
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [CRC_W-1:0]  i_m_tdata,    // [15:0] checksum
    output int unsigned       o_sums_pending,
    output int unsigned       o_mismatches
);

    localparam logic [CRC_W-1:0] GEN_POLY = 16'h8005;

    // How far into the current message we are; stops counting at three
    typedef enum logic [1:0] {
        SEEN_NONE = 2'd0,
        SEEN_ONE  = 2'd1,
        SEEN_TWO  = 2'd2,
        SEEN_MANY = 2'd3
    } t_seen;

    logic [CRC_W-1:0]  crc_acc;
    logic [BYTE_W-1:0] first_half;
    t_seen             seen;
    logic              half_held;

    logic [CRC_W-1:0]  sums_due[$];
    logic [CRC_W-1:0]  due_sum;
    int unsigned       mismatches;

    // Clock one word into the CRC register, top bit first
    function automatic logic [CRC_W-1:0] crc_word_in(
        input logic [CRC_W-1:0] acc,
        input logic [CRC_W-1:0] word
    );
        logic [CRC_W-1:0] r;
        logic             fb;
        r = acc;
        for (int k = CRC_W - 1; k >= 0; k--) begin
            fb = r[CRC_W-1];
            r  = {r[CRC_W-2:0], word[k]} ^ (fb ? GEN_POLY : '0);
        end
        return r;
    endfunction

    task automatic clear_message();
        crc_acc    = '0;
        first_half = '0;
        seen       = SEEN_NONE;
        half_held  = 1'b0;
    endtask

    task automatic report_mismatch(
        input string            what,
        input logic [CRC_W-1:0] got,
        input logic [CRC_W-1:0] want
    );
        $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Advance the message state by one byte; queue the checksum on the last byte
    task automatic take_byte(input logic [BYTE_W-1:0] b, input logic lst);
        logic [CRC_W-1:0] sum;
        sum = '0;
        case (seen)
            SEEN_NONE: begin
                first_half = b;
            end
            SEEN_ONE: begin
                crc_acc = {first_half, b};
                sum     = crc_acc;
            end
            default: begin
                if (!half_held) begin
                    // odd tail gets a zero low byte
                    first_half = b;
                    half_held  = 1'b1;
                    if (lst) begin
                        sum = crc_word_in(crc_acc, {b, 8'h00});
                    end
                end else begin
                    // full word, then a zero word if the message ends here
                    crc_acc   = crc_word_in(crc_acc, {first_half, b});
                    half_held = 1'b0;
                    if (lst) begin
                        sum = crc_word_in(crc_acc, '0);
                    end
                end
            end
        endcase
        if (seen != SEEN_MANY) begin
            seen = t_seen'(seen + 2'd1);
        end
        if (lst) begin
            sums_due.push_back(sum);
            clear_message();
        end
    endtask

    initial begin
        mismatches = 0;
        clear_message();
    end

    // Result side first: a byte taken at this edge cannot show up at the output yet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            sums_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (sums_due.size() == 0) begin
                    report_mismatch("checksum transfer with none due", i_m_tdata, '0);
                end else begin
                    due_sum = sums_due.pop_front();
                    if (i_m_tdata !== due_sum) begin
                        report_mismatch("checksum", i_m_tdata, due_sum);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                take_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_sums_pending <= sums_due.size();
        o_mismatches   <= mismatches;
    end

endmodule

>>> tb/tb_word_padded_crc16_core.sv
// Testbench top for the word padded CRC-16 core: clock, reset, byte and result traffic, verdict.
`timescale 1ns / 100ps

module tb_word_padded_crc16_core
    import wpcrc_pkg::*;
();

    localparam int unsigned BYTE_TARGET = 1200;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 12;
    localparam int unsigned HOLD_MSG    = 25;   // message index before which the sender drains

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [BYTE_W-1:0] i_s_tdata;    // [7:0] data_byte
    logic              i_s_tlast;    // last_byte
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [CRC_W-1:0]  o_m_tdata;    // [15:0] checksum

    int unsigned       sums_pending;
    int unsigned       mismatches;
    int unsigned       bytes_sent;
    int unsigned       cycle_count;
    logic              send_burst;
    logic              take_burst;

    word_padded_crc16_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    word_padded_crc16_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .o_sums_pending (sums_pending),
        .o_mismatches   (mismatches)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle gap before a transfer: none during a burst stretch
    function automatic int unsigned pick_gap(input logic burst);
        return burst ? 0 : $urandom_range(0, 5);
    endfunction

    // One byte transfer; returns right after the edge that takes it
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic lst);
        int unsigned gap;
        gap = pick_gap(send_burst);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= BYTE_W'($urandom_range(0, 255));
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= lst;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Fixed message, first byte in the top used byte of the vector
    task automatic send_fixed(input logic [63:0] bytes, input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            push_byte(bytes[8*(len-1-k) +: 8], k == len - 1);
        end
    endtask

    task automatic send_random(input int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            push_byte(BYTE_W'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // Stop offering bytes until every checksum owed has come back
    task automatic drain_sums();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sums_pending != 0) @(posedge i_clk);
    endtask

    // Byte source
    initial begin : byte_source
        int unsigned msg_idx;
        int unsigned roll;
        int unsigned len;
        msg_idx    = 0;
        bytes_sent = 0;
        send_burst = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: short-message bypasses, odd and even tails, extreme bytes
        send_fixed(64'hFF, 1);
        send_fixed(64'h00, 1);
        send_fixed(64'hFFFF, 2);
        send_fixed(64'h0001, 2);
        send_fixed(64'hFFFFFF, 3);
        send_fixed(64'h00000000, 4);
        send_burst = 1'b1;
        send_fixed(64'hFFFFFFFF, 4);
        send_fixed(64'h8001FF00A5, 5);
        send_burst = 1'b0;
        send_fixed(64'h123480, 3);

        // Random messages, mostly short, a few long ones
        while (bytes_sent < BYTE_TARGET) begin
            if (msg_idx == HOLD_MSG) begin
                drain_sums();
            end
            send_burst = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                len = $urandom_range(1, 6);
            end else if (roll < 95) begin
                len = $urandom_range(7, 24);
            end else begin
                len = $urandom_range(25, 80);
            end
            send_random(len);
            msg_idx++;
        end

        drain_sums();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sums_pending == 0) begin
            $display("word_padded_crc16_core test passed");
        end else begin
            $display("word_padded_crc16_core test failed");
        end
        $finish;
    end

    // Result sink: after a transfer, may hold tready low for a random stall, none in a burst stretch
    initial begin : result_sink
        int unsigned stall;
        take_burst = 1'b0;
        i_m_tready <= 1'b0;
        stall = $urandom_range(0, 5);
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (i_m_tready && o_m_tvalid) begin
                if ($urandom_range(0, 7) == 0) begin
                    take_burst = ~take_burst;
                end
                stall = pick_gap(take_burst);
                if (stall != 0) begin
                    i_m_tready <= 1'b0;
                end
            end else if (!i_m_tready) begin
                if (stall <= 1) begin
                    i_m_tready <= 1'b1;
                    stall = 0;
                end else begin
                    stall--;
                end
            end
            @(posedge i_clk);
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("word_padded_crc16_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
design/wpcrc_pkg.sv
design/wpcrc_accum.sv
design/wpcrc_out.sv
design/word_padded_crc16_core.sv
tb/word_padded_crc16_checker.sv
tb/tb_word_padded_crc16_core.sv
